/* rtl/triangle_rasterizer_assert.svh */
// Assertion macros used by the rasterizer checker.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef TRIANGLE_RASTERIZER_ASSERT_SVH
`define TRIANGLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication.
`define TR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tr_pkg.sv */
// ----------------------------------------------------------------------------
// tr_pkg
// Shared types and defaults for the triangle rasterizer.
// ----------------------------------------------------------------------------
package tr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIV,
    ST_POINT
  } state_t;

  typedef enum logic [2:0] {
    PH_LINE0,
    PH_LINE1,
    PH_LINE2,
    PH_FILL,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_LINE,
    OUT_FILL,
    OUT_DONE
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     init_step;
    logic     line_start;
    logic     line_point;
    logic     fill_point;
    logic     emit;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_start;
    logic in_line;
    logic in_fill;
    logic init_done;
    logic div_done;
  } status_t;

endpackage

/* rtl/tr_div.sv */
// ----------------------------------------------------------------------------
// tr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tr_div #(
  parameter int COORD_BITS = tr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [COORD_BITS+FRAC_BITS:0]   dividend,
  input  logic [COORD_BITS-1:0]           divisor,
  output logic                            done,
  output logic [COORD_BITS+FRAC_BITS:0]   quot
);

  localparam int DW = COORD_BITS + FRAC_BITS + 1;
  localparam int CNTW = $clog2(DW + 1);

  logic                  busy;
  logic [CNTW-1:0]       cnt;
  logic [DW-1:0]         n;
  logic [COORD_BITS-1:0] r;
  logic [COORD_BITS-1:0] d;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  assign trial = {r, n[DW-1]};
  assign diff  = trial - {1'b0, d};
  assign ge    = trial >= {1'b0, d};
  assign quot  = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into n from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      n <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      r <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      n <= {n[DW-2:0], ge};
    end
  end

endmodule

/* rtl/tr_ctrl.sv */
// ----------------------------------------------------------------------------
// tr_ctrl
// Sequencer: takes items, issues datapath commands, waits on units.
// ----------------------------------------------------------------------------
module tr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             action,
  output logic             in_ready,
  input  tr_pkg::status_t  sts,
  output tr_pkg::cmd_t     cmd
);

  tr_pkg::state_t state, state_next;
  logic           xfer;

  assign xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tr_pkg::ST_IDLE: begin
        if (xfer) begin
          if (!action) begin
            state_next = tr_pkg::ST_INIT;
          end else if (sts.need_start) begin
            state_next = tr_pkg::ST_DIV;
          end
        end
      end
      tr_pkg::ST_INIT: begin
        if (sts.init_done) state_next = tr_pkg::ST_IDLE;
      end
      tr_pkg::ST_DIV: begin
        if (sts.div_done) state_next = tr_pkg::ST_POINT;
      end
      tr_pkg::ST_POINT: state_next = tr_pkg::ST_IDLE;
      default: state_next = tr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.out_sel = tr_pkg::OUT_ZERO;
    case (state)
      tr_pkg::ST_IDLE: begin
        in_ready = sts.out_free;
        if (xfer) begin
          if (!action) begin
            cmd.load = 1'b1;
          end else if (sts.need_start) begin
            cmd.line_start = 1'b1;
          end else if (sts.in_line) begin
            cmd.line_point = 1'b1;
            cmd.emit       = 1'b1;
            cmd.out_sel    = tr_pkg::OUT_LINE;
          end else if (sts.in_fill) begin
            cmd.fill_point = 1'b1;
            cmd.emit       = 1'b1;
            cmd.out_sel    = tr_pkg::OUT_FILL;
          end else begin
            cmd.emit    = 1'b1;
            cmd.out_sel = tr_pkg::OUT_DONE;
          end
        end
      end
      tr_pkg::ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_done) begin
          cmd.emit    = 1'b1;
          cmd.out_sel = tr_pkg::OUT_ZERO;
        end
      end
      tr_pkg::ST_DIV: begin
      end
      tr_pkg::ST_POINT: begin
        cmd.line_point = 1'b1;
        cmd.emit       = 1'b1;
        cmd.out_sel    = tr_pkg::OUT_LINE;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/tr_dp.sv */
// ----------------------------------------------------------------------------
// tr_dp
// Datapath: triangle store, DDA line stepper, incremental edge-function
// scan and the output register.
// ----------------------------------------------------------------------------
module tr_dp #(
  parameter int COORD_BITS = tr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tr_pkg::cmd_t          cmd,
  output tr_pkg::status_t       sts,
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  input  logic [COORD_BITS-1:0] bx,
  input  logic [COORD_BITS-1:0] by_coord,
  input  logic [COORD_BITS-1:0] cx,
  input  logic [COORD_BITS-1:0] cy,
  input  logic                  fill_on,
  input  logic [31:0]           pen_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [31:0]           pixel_color,
  output logic                  write_pixel,
  output logic                  finished
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int SW  = C + 1;
  localparam int ACC = C + F + 2;
  localparam int STW = F + 2;
  localparam int DW  = C + F + 1;
  localparam int PW  = 2 * SW;
  localparam int EW  = 2 * C + 3;

  // triangle
  logic [C-1:0]          vx [3];
  logic [C-1:0]          vy [3];
  logic signed [SW-1:0]  da [3];   // dE/dx of each edge
  logic signed [SW-1:0]  db [3];   // -dE/dy of each edge
  logic                  fill_flag;
  logic [31:0]           color;
  logic [C-1:0]          xmin, xmax, ymin, ymax;

  // line stepper
  tr_pkg::phase_t        phase;
  logic                  line_started;
  logic signed [ACC-1:0] x_acc, y_acc;
  logic signed [STW-1:0] x_step, y_step;
  logic [C-1:0]          line_count, line_length;
  logic                  x_neg, y_neg, len_zero;

  // fill scan
  logic [C-1:0]          scan_x, scan_y;
  logic signed [EW-1:0]  ea [3];
  logic signed [EW-1:0]  er [3];
  logic signed [PW-1:0]  prod;
  logic [2:0]            init_k;

  function automatic logic [C-1:0] min3(input logic [C-1:0] a, b, c);
    logic [C-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [C-1:0] max3(input logic [C-1:0] a, b, c);
    logic [C-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [C-1:0] round_acc(input logic signed [ACC-1:0] a);
    logic signed [ACC-1:0]   v;
    logic signed [ACC-F-1:0] p;
    v = a + $signed({{(ACC-F){1'b0}}, 1'b1, {(F-1){1'b0}}});
    p = v[ACC-1:F];
    if (v < 0) return '0;
    if (p > $signed({2'b00, {C{1'b1}}})) return {C{1'b1}};
    return p[C-1:0];
  endfunction

  function automatic logic signed [EW-1:0] sext_d(input logic signed [SW-1:0] d);
    return {{(EW-SW){d[SW-1]}}, d};
  endfunction

  // ---------------- line start: endpoints, lengths, divider operands
  logic [1:0]            ia, ib;
  logic signed [SW-1:0]  dx, dy;
  logic [C-1:0]          adx, ady, steps;
  logic [DW-1:0]         x_dvd, y_dvd;
  logic                  xdiv_done, ydiv_done;
  logic [DW-1:0]         x_quot, y_quot;
  logic signed [STW-1:0] x_qs, y_qs;

  always_comb begin
    case (phase)
      tr_pkg::PH_LINE0: begin ia = 2'd0; ib = 2'd1; end
      tr_pkg::PH_LINE1: begin ia = 2'd1; ib = 2'd2; end
      tr_pkg::PH_LINE2: begin ia = 2'd2; ib = 2'd0; end
      default:          begin ia = 2'd0; ib = 2'd1; end
    endcase
  end

  assign dx    = $signed({1'b0, vx[ib]}) - $signed({1'b0, vx[ia]});
  assign dy    = $signed({1'b0, vy[ib]}) - $signed({1'b0, vy[ia]});
  assign adx   = dx[SW-1] ? C'(-dx) : dx[C-1:0];
  assign ady   = dy[SW-1] ? C'(-dy) : dy[C-1:0];
  assign steps = (adx > ady) ? adx : ady;
  assign x_dvd = {1'b0, adx, {F{1'b0}}} + {{(DW-C+1){1'b0}}, steps[C-1:1]};
  assign y_dvd = {1'b0, ady, {F{1'b0}}} + {{(DW-C+1){1'b0}}, steps[C-1:1]};

  tr_div #(.COORD_BITS(C), .FRAC_BITS(F)) u_xdiv (
    .clk(clk), .rst(rst), .start(cmd.line_start),
    .dividend(x_dvd), .divisor(steps), .done(xdiv_done), .quot(x_quot)
  );

  tr_div #(.COORD_BITS(C), .FRAC_BITS(F)) u_ydiv (
    .clk(clk), .rst(rst), .start(cmd.line_start),
    .dividend(y_dvd), .divisor(steps), .done(ydiv_done), .quot(y_quot)
  );

  assign x_qs = $signed({1'b0, x_quot[F:0]});
  assign y_qs = $signed({1'b0, y_quot[F:0]});

  // ---------------- line point
  logic [C-1:0] line_px, line_py;
  logic         line_end, line_fin;

  assign line_px  = round_acc(x_acc);
  assign line_py  = round_acc(y_acc);
  assign line_end = line_count >= line_length;
  assign line_fin = line_end && (phase == tr_pkg::PH_LINE2) && !fill_flag;

  // ---------------- fill point
  logic fill_wr, x_end, y_end, fill_fin;

  assign fill_wr = (!ea[0][EW-1] && !ea[1][EW-1] && !ea[2][EW-1]) ||
                   ((ea[0][EW-1] || ea[0] == '0) && (ea[1][EW-1] || ea[1] == '0) &&
                    (ea[2][EW-1] || ea[2] == '0));
  assign x_end    = scan_x >= xmax;
  assign y_end    = scan_y >= ymax;
  assign fill_fin = x_end && y_end;

  // ---------------- edge init: one product per cycle, then accumulate
  logic [1:0]           mi, ai;
  logic [2:0]           km1;
  logic signed [SW-1:0] opa, opb;

  assign km1 = init_k - 3'd1;

  always_comb begin
    case (init_k)
      3'd0, 3'd1: mi = 2'd0;
      3'd2, 3'd3: mi = 2'd1;
      3'd4, 3'd5: mi = 2'd2;
      default:    mi = 2'd0;
    endcase
    case (km1)
      3'd0, 3'd1: ai = 2'd0;
      3'd2, 3'd3: ai = 2'd1;
      3'd4, 3'd5: ai = 2'd2;
      default:    ai = 2'd0;
    endcase
    if (init_k[0]) begin
      opa = $signed({1'b0, ymin}) - $signed({1'b0, vy[mi]});
      opb = db[mi];
    end else begin
      opa = $signed({1'b0, xmin}) - $signed({1'b0, vx[mi]});
      opb = da[mi];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step) prod <= opa * opb;
  end

  // ---------------- control-like state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tr_pkg::PH_DONE;
      line_started <= 1'b0;
      init_k       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        phase        <= tr_pkg::PH_LINE0;
        line_started <= 1'b0;
        init_k       <= '0;
      end else if (cmd.init_step && init_k != 3'd6) begin
        init_k <= init_k + 3'd1;
      end
      if (cmd.line_start) line_started <= 1'b1;
      if (cmd.line_point && line_end) begin
        line_started <= 1'b0;
        case (phase)
          tr_pkg::PH_LINE0: phase <= tr_pkg::PH_LINE1;
          tr_pkg::PH_LINE1: phase <= tr_pkg::PH_LINE2;
          tr_pkg::PH_LINE2: phase <= fill_flag ? tr_pkg::PH_FILL : tr_pkg::PH_DONE;
          default:          phase <= tr_pkg::PH_DONE;
        endcase
      end
      if (cmd.fill_point && fill_fin) phase <= tr_pkg::PH_DONE;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx[0] <= ax; vy[0] <= ay;
      vx[1] <= bx; vy[1] <= by_coord;
      vx[2] <= cx; vy[2] <= cy;
      da[0] <= $signed({1'b0, by_coord}) - $signed({1'b0, ay});
      da[1] <= $signed({1'b0, cy}) - $signed({1'b0, by_coord});
      da[2] <= $signed({1'b0, ay}) - $signed({1'b0, cy});
      db[0] <= $signed({1'b0, bx}) - $signed({1'b0, ax});
      db[1] <= $signed({1'b0, cx}) - $signed({1'b0, bx});
      db[2] <= $signed({1'b0, ax}) - $signed({1'b0, cx});
      fill_flag  <= fill_on;
      color      <= pen_color;
      xmin       <= min3(ax, bx, cx);
      xmax       <= max3(ax, bx, cx);
      ymin       <= min3(ay, by_coord, cy);
      ymax       <= max3(ay, by_coord, cy);
      scan_x     <= min3(ax, bx, cx);
      scan_y     <= min3(ay, by_coord, cy);
      line_count <= '0;
      for (int i = 0; i < 3; i++) begin
        ea[i] <= '0;
        er[i] <= '0;
      end
    end

    // E = (x-x1)*da - (y-y1)*db, built up term by term
    if (cmd.init_step && init_k != 3'd0) begin
      if (km1[0]) begin
        ea[ai] <= ea[ai] - {prod[PW-1], prod};
        er[ai] <= er[ai] - {prod[PW-1], prod};
      end else begin
        ea[ai] <= ea[ai] + {prod[PW-1], prod};
        er[ai] <= er[ai] + {prod[PW-1], prod};
      end
    end

    if (cmd.line_start) begin
      x_acc       <= $signed({2'b00, vx[ia], {F{1'b0}}});
      y_acc       <= $signed({2'b00, vy[ia], {F{1'b0}}});
      line_length <= steps;
      line_count  <= '0;
      x_neg       <= dx[SW-1];
      y_neg       <= dy[SW-1];
      len_zero    <= (steps == '0);
    end

    if (xdiv_done) x_step <= len_zero ? '0 : (x_neg ? -x_qs : x_qs);
    if (ydiv_done) y_step <= len_zero ? '0 : (y_neg ? -y_qs : y_qs);

    if (cmd.line_point && !line_end) begin
      line_count <= line_count + 1'b1;
      x_acc      <= x_acc + {{(ACC-STW){x_step[STW-1]}}, x_step};
      y_acc      <= y_acc + {{(ACC-STW){y_step[STW-1]}}, y_step};
    end

    if (cmd.fill_point && !fill_fin) begin
      if (x_end) begin
        scan_y <= scan_y + 1'b1;
        scan_x <= xmin;
        for (int i = 0; i < 3; i++) begin
          er[i] <= er[i] - sext_d(db[i]);
          ea[i] <= er[i] - sext_d(db[i]);
        end
      end else begin
        scan_x <= scan_x + 1'b1;
        for (int i = 0; i < 3; i++) begin
          ea[i] <= ea[i] + sext_d(da[i]);
        end
      end
    end

    if (cmd.emit) begin
      case (cmd.out_sel)
        tr_pkg::OUT_LINE: begin
          pixel_x     <= line_px;
          pixel_y     <= line_py;
          pixel_color <= color;
          write_pixel <= 1'b1;
          finished    <= line_fin;
        end
        tr_pkg::OUT_FILL: begin
          pixel_x     <= scan_x;
          pixel_y     <= scan_y;
          pixel_color <= color;
          write_pixel <= fill_wr;
          finished    <= fill_fin;
        end
        tr_pkg::OUT_DONE: begin
          pixel_x     <= '0;
          pixel_y     <= '0;
          pixel_color <= '0;
          write_pixel <= 1'b0;
          finished    <= 1'b1;
        end
        default: begin
          pixel_x     <= '0;
          pixel_y     <= '0;
          pixel_color <= '0;
          write_pixel <= 1'b0;
          finished    <= 1'b0;
        end
      endcase
    end
  end

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.in_line    = (phase == tr_pkg::PH_LINE0) || (phase == tr_pkg::PH_LINE1) ||
                          (phase == tr_pkg::PH_LINE2);
  assign sts.need_start = sts.in_line && !line_started;
  assign sts.in_fill    = (phase == tr_pkg::PH_FILL);
  assign sts.init_done  = (init_k == 3'd6);
  assign sts.div_done   = xdiv_done;

endmodule

/* rtl/triangle_rasterizer.sv */
// ----------------------------------------------------------------------------
// triangle_rasterizer
// DDA outline of edges AB, BC, CA, then optional edge-function box fill.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | action, ax, ay, bx, by_coord, cx, cy,
//          |                      | fill_on, pen_color
//  output  | out_valid/ out_ready | pixel_x, pixel_y, pixel_color,
//          |                      | write_pixel, finished
//
// Line and fill steps: one transfer per cycle while out_ready stays high.
// First step of each edge waits on the bit-serial increment dividers.
// Load waits on the single edge multiplier building three start
// values. rst is synchronous and clears control only. A stalled
// output holds the next input off.
module triangle_rasterizer #(
  parameter int COORD_BITS = tr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  input  logic [COORD_BITS-1:0] bx,
  input  logic [COORD_BITS-1:0] by_coord,
  input  logic [COORD_BITS-1:0] cx,
  input  logic [COORD_BITS-1:0] cy,
  input  logic                  fill_on,
  input  logic [31:0]           pen_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [31:0]           pixel_color,
  output logic                  write_pixel,
  output logic                  finished
);

  tr_pkg::cmd_t    cmd;
  tr_pkg::status_t sts;

  tr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .action(action),
    .in_ready(in_ready), .sts(sts), .cmd(cmd)
  );

  tr_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord), .cx(cx), .cy(cy),
    .fill_on(fill_on), .pen_color(pen_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
    .write_pixel(write_pixel), .finished(finished)
  );

endmodule

/* rtl/tr_checker.sv */
// ----------------------------------------------------------------------------
// tr_checker
// Port-level checks on the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_rasterizer_assert.svh"

module tr_checker #(
  parameter int COORD_BITS = tr_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  action,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic [31:0]           pixel_color,
  input logic                  write_pixel,
  input logic                  finished
);

  `TR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `TR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color) && $stable(write_pixel) && $stable(finished), "stalled result changed")
  `TR_ASSERT_IMPL(a_ready_free, in_ready, !out_valid || out_ready, "input taken with output slot full")
  `TR_ASSERT_NEXT(a_load_busy, in_valid && in_ready && !action, !out_valid && !in_ready, "load result too early")

endmodule

bind triangle_rasterizer tr_checker #(.COORD_BITS(COORD_BITS)) u_tr_checker (.*);
